// ===== rtl/wsfd_pkg.sv =====
package wsfd_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
	localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
	localparam logic [1:0] REG_HOLD_THRESH = 2'd2;

	// configuration reset values
	localparam logic [7:0]  SYNC_FIRST_RST  = 8'h5A;
	localparam logic [7:0]  SYNC_SECOND_RST = 8'hA5;
	localparam logic [15:0] HOLD_THRESH_RST = 16'd1500;

	// frame layout
	localparam int PAYLOAD_BYTES = 8;
	localparam int BODY_FIRST    = 2;
	localparam int BODY_LAST     = 9;
	localparam int CHECKSUM_IDX  = 10;

	typedef enum logic [1:0] {
		PH_HUNT  = 2'd0,
		PH_FIRST = 2'd1,
		PH_BODY  = 2'd2
	} phase_t;

	// a checked frame handed from the parser to the filter
	typedef struct packed {
		logic                                good;
		logic [PAYLOAD_BYTES-1:0][7:0]       payload;
	} frame_t;

	typedef struct packed {
		logic signed [15:0] left_front;
		logic signed [15:0] right_front;
		logic signed [15:0] left_back;
		logic signed [15:0] right_back;
	} speeds_t;

endpackage

// ===== rtl/wsfd_if.sv =====
interface wsfd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface wsfd_speed_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] speed_left_front;
	logic signed [15:0] speed_right_front;
	logic signed [15:0] speed_left_back;
	logic signed [15:0] speed_right_back;

	modport source (output valid, output speed_left_front, output speed_right_front,
		output speed_left_back, output speed_right_back, input ready);
	modport sink (input valid, input speed_left_front, input speed_right_front,
		input speed_left_back, input speed_right_back, output ready);
endinterface

interface wsfd_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/wsfd_parser.sv =====
module wsfd_parser
	import wsfd_pkg::*;
#(
	parameter int FRAME_LENGTH = 13
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [7:0] rx_byte,
	input  logic [7:0] sync_first,
	input  logic [7:0] sync_second,
	output frame_t     frame
);

	localparam int IDX_W = $clog2(FRAME_LENGTH);
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(FRAME_LENGTH - 1);
	localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(BODY_FIRST);
	localparam logic [IDX_W-1:0] BLAST_IDX = IDX_W'(BODY_LAST);
	localparam logic [IDX_W-1:0] CSUM_IDX  = IDX_W'(CHECKSUM_IDX);

	phase_t                        phase_q, phase_d;
	logic [IDX_W-1:0]              idx_q, idx_d;
	logic [7:0]                    sum_q, sum_d;
	logic [7:0]                    csum_q;
	logic [PAYLOAD_BYTES-1:0][7:0] payload_q;
	logic [IDX_W-1:0]              idx_off;
	logic                          in_body;
	logic                          is_last;
	logic [7:0]                    csum_cmp;

	// frame position decode
	assign in_body  = (idx_q >= FIRST_IDX) && (idx_q <= BLAST_IDX);
	assign is_last  = (idx_q == LAST_IDX);
	assign idx_off  = idx_q - FIRST_IDX;
	assign csum_cmp = (idx_q == CSUM_IDX) ? rx_byte : csum_q;

	// header hunt and body collection
	always_comb begin
		phase_d       = phase_q;
		idx_d         = idx_q;
		sum_d         = sum_q;
		frame.good    = 1'b0;
		frame.payload = payload_q;
		if (en) begin
			case (phase_q)
				PH_HUNT: begin
					if (rx_byte == sync_first)
						phase_d = PH_FIRST;
				end
				PH_FIRST: begin
					if (rx_byte == sync_second) begin
						phase_d = PH_BODY;
						idx_d   = FIRST_IDX;
						sum_d   = '0;
					end else if (rx_byte != sync_first) begin
						phase_d = PH_HUNT;
					end
				end
				PH_BODY: begin
					if (in_body)
						sum_d = sum_q + rx_byte;
					if (is_last) begin
						phase_d    = PH_HUNT;
						idx_d      = '0;
						frame.good = (sum_q == csum_cmp);
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
				default: begin
					phase_d = PH_HUNT;
				end
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			idx_q   <= '0;
			sum_q   <= '0;
		end else begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			sum_q   <= sum_d;
		end
	end

	// payload and checksum capture
	always_ff @(posedge clk) begin
		if (en && phase_q == PH_BODY) begin
			if (in_body)
				payload_q[idx_off[2:0]] <= rx_byte;
			if (idx_q == CSUM_IDX)
				csum_q <= rx_byte;
		end
	end

	a_body_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> idx_q >= FIRST_IDX && idx_q <= LAST_IDX)
		else $error("frame position outside the frame");

	a_good_in_body: assert property (@(posedge clk) disable iff (!arst_n)
		frame.good |-> phase_q == PH_BODY && is_last && en)
		else $error("frame reported away from its last byte");

	a_hunt_after_frame: assert property (@(posedge clk) disable iff (!arst_n)
		frame.good |=> phase_q == PH_HUNT && idx_q == '0)
		else $error("no return to hunting after a frame");

endmodule

// ===== rtl/wsfd_filter.sv =====
module wsfd_filter
	import wsfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  frame_t      frame,
	input  logic [15:0] hold_threshold,
	output speeds_t     speeds
);

	logic signed [15:0] prev_q;
	logic signed [15:0] val  [4];
	logic signed [15:0] refv [4];
	logic signed [15:0] res  [4];
	logic signed [16:0] diff [4];
	logic        [16:0] mag  [4];

	// sign-magnitude to two's complement, negative zero gives zero
	function automatic logic signed [15:0] decode_speed(input logic [7:0] hi,
		input logic [7:0] lo);
		logic signed [15:0] m;
		m = {1'b0, hi[6:0], lo};
		return hi[7] ? -m : m;
	endfunction

	// each value is compared with the raw value before it, so all four run side by side
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			val[k] = decode_speed(frame.payload[2*k], frame.payload[2*k+1]);
		end
		refv[0] = prev_q;
		refv[1] = val[0];
		refv[2] = val[1];
		refv[3] = val[2];
		for (int k = 0; k < 4; k++) begin
			diff[k] = {val[k][15], val[k]} - {refv[k][15], refv[k]};
			mag[k]  = diff[k][16] ? 17'(-diff[k]) : 17'(diff[k]);
			res[k]  = (mag[k] < {1'b0, hold_threshold}) ? refv[k] : val[k];
		end
	end

	assign speeds.left_front  = res[0];
	assign speeds.right_front = res[1];
	assign speeds.left_back   = res[2];
	assign speeds.right_back  = res[3];

	// last raw right back value of a good frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (frame.good) begin
			prev_q <= val[3];
		end
	end

endmodule

// ===== rtl/wheel_speed_frame_decoder_unit.sv =====
// Wheel speed frame decoder. Bytes from a serial receiver arrive on rx; the block hunts for
// the two header bytes, collects a FRAME_LENGTH byte frame, checks the 8-bit sum of bytes
// 2..9 against byte 10 and, for a good frame, delivers four filtered two's complement wheel
// speeds (LF, RF, LB, RB) on speed. The last byte is parsed and filtered combinationally
// once it leaves the input register, and its result is held in the result register, which
// drives speed.valid; while an earlier result is waiting, the byte stays in the input
// register. Bad frames produce nothing. The input register and the result register bracket
// the parsing and filtering, so a byte can be taken every cycle unless a finished result
// waits on speed.ready: then the input register holds one byte and further bytes stall
// until the result is taken. Registers (cfg.index): 0 first header byte, 1 second header
// byte, 2 jump filter hold threshold; write them only while the block is idle.
module wheel_speed_frame_decoder_unit
	import wsfd_pkg::*;
#(
	parameter int FRAME_LENGTH = 13
) (
	input logic         clk,
	input logic         arst_n,
	wsfd_byte_if.sink   rx,
	wsfd_speed_if.source speed,
	wsfd_cfg_if.sink    cfg
);

	logic [7:0]  sync_first_q;
	logic [7:0]  sync_second_q;
	logic [15:0] hold_thresh_q;
	logic        byte_valid_s1;
	logic [7:0]  byte_s1;
	logic        proc_en;
	logic        out_valid_q;
	speeds_t     out_q;
	frame_t      frame;
	speeds_t     speeds;

	// configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
			hold_thresh_q <= HOLD_THRESH_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_SYNC_FIRST:  sync_first_q  <= cfg.data[7:0];
				REG_SYNC_SECOND: sync_second_q <= cfg.data[7:0];
				REG_HOLD_THRESH: hold_thresh_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// input register, drained whenever the result slot is free or being emptied
	assign proc_en  = byte_valid_s1 && (!out_valid_q || speed.ready);
	assign rx.ready = !byte_valid_s1 || proc_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			byte_valid_s1 <= 1'b1;
		end else if (proc_en) begin
			byte_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready)
			byte_s1 <= rx.rx_byte;
	end

	wsfd_parser #(
		.FRAME_LENGTH(FRAME_LENGTH)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (proc_en),
		.rx_byte     (byte_s1),
		.sync_first  (sync_first_q),
		.sync_second (sync_second_q),
		.frame       (frame)
	);

	wsfd_filter u_filter (
		.clk            (clk),
		.arst_n         (arst_n),
		.frame          (frame),
		.hold_threshold (hold_thresh_q),
		.speeds         (speeds)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (frame.good) begin
			out_valid_q <= 1'b1;
		end else if (speed.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.good)
			out_q <= speeds;
	end

	assign speed.valid             = out_valid_q;
	assign speed.speed_left_front  = out_q.left_front;
	assign speed.speed_right_front = out_q.right_front;
	assign speed.speed_left_back   = out_q.left_back;
	assign speed.speed_right_back  = out_q.right_back;

	a_empty_takes_byte: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_valid_s1 |-> rx.ready)
		else $error("input register empty but request refused");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !speed.ready |-> !proc_en && !frame.good)
		else $error("pending result would be overwritten");

	a_good_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		frame.good |=> out_valid_q)
		else $error("good frame produced no result");

endmodule
